// ----- sv/fpa_pkg.sv -----
// Shared types, widths and operation codes for the Q17.14 fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
    localparam int DATA_W = 32;
    localparam int FRAC_BITS_DEF = 14;

    localparam logic [3:0] OP_FROM_INT  = 4'd0;
    localparam logic [3:0] OP_TRUNC     = 4'd1;
    localparam logic [3:0] OP_ROUND     = 4'd2;
    localparam logic [3:0] OP_ADD       = 4'd3;
    localparam logic [3:0] OP_ADD_INT   = 4'd4;
    localparam logic [3:0] OP_SUB       = 4'd5;
    localparam logic [3:0] OP_SUB_INT   = 4'd6;
    localparam logic [3:0] OP_MUL       = 4'd7;
    localparam logic [3:0] OP_MUL_INT   = 4'd8;
    localparam logic [3:0] OP_DIV       = 4'd9;
    localparam logic [3:0] OP_DIV_INT   = 4'd10;
    localparam logic [3:0] OP_INT_RATIO = 4'd11;
    localparam logic [3:0] OP_LESS      = 4'd12;

    typedef logic [3:0] t_op;

    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  res;
        logic               is_div;
        logic               qneg;
        logic               dz;
    } t_side;
endpackage
`default_nettype wire

// ----- sv/fpa_if.sv -----
// Request and response channel interfaces of the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
interface fpa_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic signed [31:0] a;
    logic signed [31:0] b;
    modport source (output valid, func, a, b, input ready);
    modport sink (input valid, func, a, b, output ready);
endinterface

interface fpa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               div_zero;
    modport source (output valid, result, div_zero, input ready);
    modport sink (input valid, result, div_zero, output ready);
endinterface
`default_nettype wire

// ----- sv/fpa_mul.sv -----
// Operand decode, signed multiply and product scaling stages.
`timescale 1ns / 1ps
`default_nettype none
module fpa_mul #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int DW = 32 + FRAC_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire fpa_pkg::t_op        i_op,
    input  wire logic signed [31:0]  i_a,
    input  wire logic signed [31:0]  i_b,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output fpa_pkg::t_side           o_side,
    output logic [DW-1:0]            o_num,
    output logic [31:0]              o_den
);
    import fpa_pkg::*;

    localparam logic [32:0] HALF = 33'(1) << (FRAC_BITS - 1);
    localparam logic signed [63:0] FMASK = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    logic               r_bv, r_cv;
    logic signed [63:0] r_prod;
    t_side              r_bside, r_cside;
    logic [DW-1:0]      r_bnum, r_cnum;
    logic [31:0]        r_bden, r_cden;

    logic               w_rdy_b, w_rdy_c;
    logic signed [63:0] w_prod, w_padj;
    logic [31:0]        w_mag_a, w_mag_b, w_res, w_mres;
    logic [32:0]        w_rnd;
    logic               w_isdiv;
    t_side              n_bside, n_cside;
    logic [DW-1:0]      n_num;

    assign w_rdy_c = !r_cv || i_ready;
    assign w_rdy_b = !r_bv || w_rdy_c;
    assign o_ready = w_rdy_b;

    assign w_prod  = i_a * i_b;
    assign w_mag_a = i_a[31] ? 32'(-i_a) : i_a;
    assign w_mag_b = i_b[31] ? 32'(-i_b) : i_b;
    assign w_rnd   = ({1'b0, w_mag_a} + HALF) >> FRAC_BITS;
    assign w_isdiv = (i_op == OP_DIV) || (i_op == OP_DIV_INT) || (i_op == OP_INT_RATIO);

    always_comb begin
        unique case (i_op)
            OP_FROM_INT: w_res = 32'(i_a <<< FRAC_BITS);
            OP_TRUNC:    w_res = 32'(i_a >>> FRAC_BITS);
            OP_ROUND:    w_res = i_a[31] ? 32'(-w_rnd) : w_rnd[31:0];
            OP_ADD:      w_res = 32'(i_a + i_b);
            OP_ADD_INT:  w_res = 32'(i_a + (i_b <<< FRAC_BITS));
            OP_SUB:      w_res = 32'(i_a - i_b);
            OP_SUB_INT:  w_res = 32'(i_a - (i_b <<< FRAC_BITS));
            OP_LESS:     w_res = (i_a < i_b) ? 32'd1 : 32'd0;
            default:     w_res = '0;
        endcase
        n_num = (i_op == OP_DIV_INT) ? DW'(w_mag_a) : {w_mag_a, {FRAC_BITS{1'b0}}};
        n_bside.op     = i_op;
        n_bside.res    = w_res;
        n_bside.is_div = w_isdiv;
        n_bside.qneg   = i_a[31] ^ i_b[31];
        n_bside.dz     = w_isdiv && (i_b == 32'sd0);
    end

    assign w_padj = r_prod[63] ? (r_prod + FMASK) : r_prod;

    always_comb begin
        unique case (r_bside.op)
            OP_MUL:     w_mres = 32'(w_padj >>> FRAC_BITS);
            OP_MUL_INT: w_mres = r_prod[31:0];
            default:    w_mres = r_bside.res;
        endcase
        n_cside     = r_bside;
        n_cside.res = w_mres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
            r_cv <= 1'b0;
        end else begin
            if (w_rdy_b) r_bv <= i_valid;
            if (w_rdy_c) r_cv <= r_bv;
        end
        if (w_rdy_b && i_valid) begin
            r_prod  <= w_prod;
            r_bside <= n_bside;
            r_bnum  <= n_num;
            r_bden  <= w_mag_b;
        end
        if (w_rdy_c && r_bv) begin
            r_cside <= n_cside;
            r_cnum  <= r_bnum;
            r_cden  <= r_bden;
        end
    end

    assign o_valid = r_cv;
    assign o_side  = r_cside;
    assign o_num   = r_cnum;
    assign o_den   = r_cden;
endmodule
`default_nettype wire

// ----- sv/fpa_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int DW = 32 + FRAC_BITS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire fpa_pkg::t_side  i_side,
    input  wire logic [DW-1:0]   i_num,
    input  wire logic [31:0]     i_den,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output fpa_pkg::t_side       o_side,
    output logic [DW-1:0]        o_quo
);
    import fpa_pkg::*;

    logic          r_v   [DW];
    logic [31:0]   r_rem [DW];
    logic [DW-1:0] r_nq  [DW];
    logic [31:0]   r_den [DW];
    t_side         r_side[DW];
    logic          w_rdy [DW+1];

    assign w_rdy[DW] = i_ready;
    assign o_ready   = w_rdy[0];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic          w_iv;
        logic [31:0]   w_irem, w_iden;
        logic [DW-1:0] w_inq;
        t_side         w_iside;
        logic [32:0]   w_t, w_d;
        logic          w_q;

        if (k == 0) begin : g_first
            assign w_iv    = i_valid;
            assign w_irem  = '0;
            assign w_inq   = i_num;
            assign w_iden  = i_den;
            assign w_iside = i_side;
        end else begin : g_next
            assign w_iv    = r_v[k-1];
            assign w_irem  = r_rem[k-1];
            assign w_inq   = r_nq[k-1];
            assign w_iden  = r_den[k-1];
            assign w_iside = r_side[k-1];
        end

        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
        assign w_t = {w_irem, w_inq[DW-1]};
        assign w_d = {1'b0, w_iden};
        assign w_q = (w_t >= w_d);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_iv;
            end
            if (w_rdy[k] && w_iv) begin
                r_rem[k]  <= w_q ? 32'(w_t - w_d) : w_t[31:0];
                r_nq[k]   <= {w_inq[DW-2:0], w_q};
                r_den[k]  <= w_iden;
                r_side[k] <= w_iside;
            end
        end
    end

    assign o_valid = r_v[DW-1];
    assign o_side  = r_side[DW-1];
    assign o_quo   = r_nq[DW-1];

`ifndef ASSERT_OFF
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[DW-1] && (r_den[DW-1] != 32'd0) |-> r_rem[DW-1] < r_den[DW-1])
        else $error("remainder not below divisor");
`endif
endmodule
`default_nettype wire

// ----- sv/fixed_point_17_14_alu_core.sv -----
// Top level of the Q17.14 fixed-point ALU: input, multiply, divide and output stages.
`timescale 1ns / 1ps
`default_nettype none
// Fully pipelined ALU: one request may enter every cycle unless o_rsp.ready
// holds the pipeline back, and each gives one response, whatever the
// operation. Every request passes the restoring divider, one quotient bit per
// stage over 32 + FRAC_BITS stages, behind an input stage, a multiply stage, a
// product scaling stage, and followed by the output register. Results wrap to
// 32 bits; a division by zero returns 0 with div_zero set.
module fixed_point_17_14_alu_core #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpa_req_if.sink   i_req,
    fpa_rsp_if.source o_rsp
);
    import fpa_pkg::*;

    localparam int DW = 32 + FRAC_BITS;

    logic               r_av;
    t_op                r_aop;
    logic signed [31:0] r_aa, r_ab;
    logic               r_ov, r_odz;
    logic [31:0]        r_ores;
    t_op                r_oop;

    logic          w_rdy_a, w_rdy_o, w_mul_rdy, w_mul_v, w_div_rdy, w_div_v;
    t_side         w_mul_side, w_div_side;
    logic [DW-1:0] w_num, w_quo;
    logic [31:0]   w_den, n_res;

    assign w_rdy_o     = !r_ov || o_rsp.ready;
    assign w_rdy_a     = !r_av || w_mul_rdy;
    assign i_req.ready = w_rdy_a;

    fpa_mul #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_av),
        .o_ready (w_mul_rdy),
        .i_op    (r_aop),
        .i_a     (r_aa),
        .i_b     (r_ab),
        .o_valid (w_mul_v),
        .i_ready (w_div_rdy),
        .o_side  (w_mul_side),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    fpa_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_v),
        .o_ready (w_div_rdy),
        .i_side  (w_mul_side),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_valid (w_div_v),
        .i_ready (w_rdy_o),
        .o_side  (w_div_side),
        .o_quo   (w_quo)
    );

    always_comb begin
        if (!w_div_side.is_div || w_div_side.dz) begin
            n_res = w_div_side.is_div ? 32'd0 : w_div_side.res;
        end else begin
            n_res = w_div_side.qneg ? 32'(-w_quo[31:0]) : w_quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_rdy_a) r_av <= i_req.valid;
            if (w_rdy_o) r_ov <= w_div_v;
        end
        if (w_rdy_a && i_req.valid) begin
            r_aop <= i_req.func;
            r_aa  <= i_req.a;
            r_ab  <= i_req.b;
        end
        if (w_rdy_o && w_div_v) begin
            r_ores <= n_res;
            r_odz  <= w_div_side.dz;
            r_oop  <= w_div_side.op;
        end
    end

    assign o_rsp.valid    = r_ov;
    assign o_rsp.result   = r_ores;
    assign o_rsp.div_zero = r_odz;

`ifndef ASSERT_OFF
    a_dz_zero_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_odz |-> r_ores == 32'd0)
        else $error("zero divisor with non-zero result");
    a_dz_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_odz |-> (r_oop == OP_DIV) || (r_oop == OP_DIV_INT) ||
            (r_oop == OP_INT_RATIO))
        else $error("div_zero on a non-division request");
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_ov && !o_rsp.ready)
        else $error("input stalled without output back-pressure");
`endif
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking regression bench for the Q17.14 fixed-point ALU core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import fpa_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = FRAC + 36;

    typedef struct packed {
        logic [31:0] result;
        logic        div_zero;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fpa_req_if req_ch ();
    fpa_rsp_if rsp_ch ();

    fixed_point_17_14_alu_core #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_answer answer_q[$];
    int      n_errors = 0;
    int      n_checked = 0;
    bit      src_idle_en = 1'b1;
    bit      sink_idle_en = 1'b1;
    int      sink_hold = 0;
    bit      op_seen[16];

    function automatic t_answer alu_predict(logic [3:0] op, logic signed [31:0] a,
                                            logic signed [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] acc;
        t_answer ans;
        wa = a;
        wb = b;
        acc = 0;
        ans.div_zero = 1'b0;
        case (op)
            OP_FROM_INT:  acc = wa <<< FRAC;
            OP_TRUNC:     acc = wa >>> FRAC;
            OP_ROUND: begin
                if (wa >= 0) acc = (wa + (64'sd1 <<< (FRAC - 1))) / (64'sd1 <<< FRAC);
                else acc = (wa - (64'sd1 <<< (FRAC - 1))) / (64'sd1 <<< FRAC);
            end
            OP_ADD:       acc = wa + wb;
            OP_ADD_INT:   acc = wa + (wb <<< FRAC);
            OP_SUB:       acc = wa - wb;
            OP_SUB_INT:   acc = wa - (wb <<< FRAC);
            OP_MUL:       acc = (wa * wb) / (64'sd1 <<< FRAC);
            OP_MUL_INT:   acc = wa * wb;
            OP_DIV, OP_INT_RATIO: begin
                if (b == 0) ans.div_zero = 1'b1;
                else acc = (wa <<< FRAC) / wb;
            end
            OP_DIV_INT: begin
                if (b == 0) ans.div_zero = 1'b1;
                else acc = wa / wb;
            end
            OP_LESS:      acc = (a < b) ? 64'sd1 : 64'sd0;
            default:      acc = 0;
        endcase
        ans.result = acc[31:0];
        return ans;
    endfunction

    task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        int gap;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= op;
        req_ch.a <= a;
        req_ch.b <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        answer_q.push_back(alu_predict(op, a, b));
        op_seen[op] = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (answer_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd1;
            4: return $urandom_range(0, 131071) - 65536;
            5: return {{15{1'b0}}, 17'($urandom)} - 32'h0000_ffff;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected response result=%h div_zero=%b", $realtime,
                         rsp_ch.result, rsp_ch.div_zero);
                n_errors++;
            end else begin
                t_answer exp_ans;
                exp_ans = answer_q.pop_front();
                n_checked++;
                if (rsp_ch.result !== exp_ans.result) begin
                    $display("%0t: result expected %h actual %h", $realtime,
                             exp_ans.result, rsp_ch.result);
                    n_errors++;
                end
                if (rsp_ch.div_zero !== exp_ans.div_zero) begin
                    $display("%0t: div_zero expected %b actual %b", $realtime,
                             exp_ans.div_zero, rsp_ch.div_zero);
                    n_errors++;
                end
            end
        end
    end

    // hold off the response side in bursts, or for a long stretch on request
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            rsp_ch.ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
            sink_hold <= $urandom_range(0, 4);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    task automatic test_directed();
        logic [31:0] edge_vals[6];
        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff, 32'h0000_2000,
                      32'hffff_e000};
        for (int op = 0; op < 16; op++)
            send_request(op[3:0], edge_vals[op % 6], edge_vals[(op + 1) % 6]);
        send_request(OP_DIV_INT, 32'h8000_0000, 32'hffff_ffff);
        send_request(OP_DIV, 32'h0001_0000, 32'd0);
        send_request(OP_INT_RATIO, 32'h7fff_ffff, 32'd0);
        send_request(OP_DIV_INT, 32'hffff_ffff, 32'd0);
        send_request(OP_ROUND, 32'hffff_e000, 32'd0);
        send_request(OP_ROUND, 32'h0000_1fff, 32'd0);
        send_request(OP_TRUNC, 32'hffff_ffff, 32'd0);
        send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_request(OP_LESS, 32'h8000_0000, 32'h7fff_ffff);
    endtask

    task automatic test_backpressure();
        drain_results();
        @(posedge i_clk);
        sink_hold = LATENCY * 3;
        @(negedge i_clk);
        for (int i = 0; i < 120; i++)
            send_request(4'($urandom_range(0, 12)), pick_operand(), pick_operand());
        drain_results();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_request($urandom_range(0, 15) <= 12 ? 4'($urandom_range(0, 12))
                         : 4'($urandom_range(13, 15)), pick_operand(), pick_operand());
    endtask

    initial begin
        int n_ops;
        req_ch.valid = 1'b0;
        req_ch.func = OP_FROM_INT;
        req_ch.a = '0;
        req_ch.b = '0;
        rsp_ch.ready = 1'b1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(300);
        test_backpressure();
        test_random(300);
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        test_random(100);
        drain_results();
        repeat (LATENCY + 10) @(negedge i_clk);
        n_ops = 0;
        for (int k = 0; k < 16; k++)
            if (op_seen[k]) n_ops++;
        $display("Covered %0d checked responses over %0d operation codes,", n_checked, n_ops);
        $display("with operand extremes, zero divisors and a long response stall.");
        if (n_errors == 0 && answer_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
